// ----- rtl/swr_pkg.sv -----
package swr_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 16;

    // Fixed field widths.
    localparam int CHAR_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int PLEN_W      = 4;
    localparam int RLEN_W      = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Window fill count; holds up to eight bytes.
    localparam int CNT_W = 4;

    // Position inside the result burst of one command (at most 16 results).
    localparam int POS_W = 5;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_LOW    = 3'd2,
        REG_REPLACEMENT_HIGH   = 3'd3,
        REG_REPLACEMENT_LENGTH = 3'd4
    } cfg_reg_t;

    // One decided step of the front, carried out later by the back.
    typedef struct packed {
        logic                 shift;        // emit the oldest window byte
        logic [CHAR_W-1:0]    shift_char;
        logic                 repl;         // emit the whole replacement
        logic [CNT_W-1:0]     flush_cnt;    // window bytes flushed at end of string
        logic [PATTERN_W-1:0] flush_bytes;  // oldest flushed byte lowest
        logic                 last;         // this step ends the string
    } cmd_t;

endpackage

// ----- rtl/swr_front.sv -----
module swr_front #(
    parameter int MAX_PATTERN = swr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [swr_pkg::CHAR_W-1:0]     in_char,
    input  logic                           in_last,
    input  logic [swr_pkg::PATTERN_W-1:0]  pattern_bytes,
    input  logic [swr_pkg::PLEN_W-1:0]     plen,
    output swr_pkg::cmd_t                  cmd,
    output logic [swr_pkg::CNT_W-1:0]      win_count
);
    import swr_pkg::*;

    logic [CHAR_W-1:0] win_reg  [MAX_PATTERN];
    logic [CHAR_W-1:0] win_next [MAX_PATTERN];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [CHAR_W-1:0] win_add [MAX_PATTERN];
    logic [CHAR_W-1:0] win_sh  [MAX_PATTERN];
    logic [CNT_W-1:0]  count_add;
    logic [CNT_W-1:0]  remain;
    logic              match;
    logic              do_shift;
    logic              do_repl;

    // Append the new byte, compare against the pattern and decide the step.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_add[i] = (CNT_W'(i) == count_reg) ? in_char : win_reg[i];
        end
        count_add = count_reg + CNT_W'(1);

        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((PLEN_W'(i) < plen) && (win_add[i] != pattern_bytes[CHAR_W*i +: CHAR_W]))
            begin
                match = 1'b0;
            end
        end

        do_repl  = (count_add == plen) && match;
        do_shift = (count_add > plen) || ((count_add == plen) && !match);

        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            win_sh[i] = win_add[i + 1];
        end
        win_sh[MAX_PATTERN - 1] = win_add[MAX_PATTERN - 1];

        if (do_shift)
        begin
            remain = count_add - CNT_W'(1);
        end
        else if (do_repl)
        begin
            remain = '0;
        end
        else
        begin
            remain = count_add;
        end

        // Command for the back.
        cmd             = '0;
        cmd.shift       = do_shift;
        cmd.shift_char  = win_add[0];
        cmd.repl        = do_repl;
        cmd.last        = in_last;
        cmd.flush_cnt   = in_last ? remain : '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cmd.flush_bytes[CHAR_W*i +: CHAR_W] = do_shift ? win_sh[i] : win_add[i];
        end

        // Window update; the end of a string empties the window.
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_next[i] = do_shift ? win_sh[i] : win_add[i];
        end
        count_next = in_last ? '0 : remain;
    end

    // Window count is control state; the window bytes are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign win_count = count_reg;

endmodule

// ----- rtl/swr_cmd_queue.sv -----
module swr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_push,
    input  swr_pkg::cmd_t q_in,
    output logic          q_full,
    input  logic          q_pop,
    output swr_pkg::cmd_t q_head,
    output logic          q_empty
);
    import swr_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = entries_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= q_in;
        end
    end

endmodule

// ----- rtl/swr_back.sv -----
module swr_back #(
    parameter int MAX_REPLACEMENT = swr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  swr_pkg::cmd_t                          cmd,
    input  logic                                   q_empty,
    output logic                                   q_pop,
    input  logic [swr_pkg::RLEN_W-1:0]             rlen,
    input  logic [swr_pkg::CHAR_W*MAX_REPLACEMENT-1:0] repl_vec,
    input  logic                                   pop,
    output logic                                   empty,
    output logic [swr_pkg::CHAR_W-1:0]             out_char,
    output logic                                   out_last,
    output logic                                   out_empty
);
    import swr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              mark_reg;
    logic              mark_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    logic [POS_W-1:0]  n_shift;
    logic [POS_W-1:0]  n_repl;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  total_eff;
    logic [POS_W-1:0]  repl_k;
    logic [POS_W-1:0]  flush_j;
    logic [CHAR_W*MAX_REPLACEMENT-1:0] repl_sh;
    logic [PATTERN_W-1:0] flush_sh;
    logic              advance;
    logic              out_take;
    logic              marker;

    assign empty     = !valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_empty = mark_reg;
    assign out_take  = pop && valid_reg;
    assign advance   = !q_empty && (!valid_reg || pop);

    // Size of the result burst of the head command and the byte at the current position.
    always_comb
    begin
        n_shift   = POS_W'(cmd.shift);
        n_repl    = cmd.repl ? rlen : '0;
        total     = n_shift + n_repl + POS_W'(cmd.flush_cnt);
        marker    = (total == '0) && cmd.last;
        total_eff = marker ? POS_W'(1) : total;
        repl_k    = pos_reg - n_shift;
        flush_j   = pos_reg - n_shift - n_repl;
        repl_sh   = repl_vec >> {repl_k, 3'b000};
        flush_sh  = cmd.flush_bytes >> {flush_j, 3'b000};
    end

    // Expand one command into its transactions, one per cycle while the output is free or popped.
    always_comb
    begin
        valid_next = valid_reg && !out_take;
        char_next  = char_reg;
        last_next  = last_reg;
        mark_next  = mark_reg;
        pos_next   = pos_reg;
        q_pop      = 1'b0;
        if (advance)
        begin
            if (total_eff == '0)
            begin
                // Nothing to emit for this step.
                q_pop = 1'b1;
            end
            else
            begin
                valid_next = 1'b1;
                mark_next  = marker;
                last_next  = cmd.last && (pos_reg == total_eff - POS_W'(1));
                if (marker)
                begin
                    char_next = '0;
                end
                else if (pos_reg < n_shift)
                begin
                    char_next = cmd.shift_char;
                end
                else if (pos_reg < n_shift + n_repl)
                begin
                    char_next = repl_sh[CHAR_W-1:0];
                end
                else
                begin
                    char_next = flush_sh[CHAR_W-1:0];
                end
                if (pos_reg == total_eff - POS_W'(1))
                begin
                    q_pop    = 1'b1;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        mark_reg <= mark_next;
    end

endmodule

// ----- rtl/stream_word_replace.sv -----
// Channel   Direction  Handshake                       Payload
// input     in         push / full                     in_char, in_last
// result    out        empty / pop                     out_char, out_last, out_empty
// config    in         cfg_write                       cfg_index, cfg_data
//
// The front takes one byte per cycle while the command queue (four entries) has room.
// The back gives one result transaction per cycle while results are popped: a step emits
// one result per byte (up to one shifted byte, the replacement and the end-of-string flush).
// Reset clears the window, queue and output register and loads the register defaults.
// A stalled result holds in the output register; the front goes on until the queue fills.
module stream_word_replace #(
    parameter int MAX_PATTERN     = swr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = swr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [swr_pkg::CHAR_W-1:0]         in_char,
    input  logic                               in_last,
    output logic                               empty,
    input  logic                               pop,
    output logic [swr_pkg::CHAR_W-1:0]         out_char,
    output logic                               out_last,
    output logic                               out_empty,
    input  logic                               cfg_write,
    input  logic [swr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swr_pkg::*;

    logic [PATTERN_W-1:0] pattern_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [RLEN_W-1:0]    rlen_reg;
    logic [CHAR_W-1:0]    repl_reg [MAX_REPLACEMENT];

    logic [PLEN_W-1:0]    plen_eff;
    logic [RLEN_W-1:0]    rlen_eff;
    logic [CHAR_W*MAX_REPLACEMENT-1:0] repl_vec;

    cmd_t                 front_cmd;
    cmd_t                 head_cmd;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 take;
    logic [CNT_W-1:0]     win_count;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= PLEN_W'(1);
            rlen_reg    <= '0;
            for (int i = 0; i < MAX_REPLACEMENT; i++)
            begin
                repl_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:      pattern_reg <= cfg_data;
                REG_PATTERN_LENGTH:     plen_reg    <= cfg_data[PLEN_W-1:0];
                REG_REPLACEMENT_LENGTH: rlen_reg    <= cfg_data[RLEN_W-1:0];
                REG_REPLACEMENT_LOW:
                begin
                    for (int i = 0; i < MAX_REPLACEMENT; i++)
                    begin
                        if (i < 8)
                        begin
                            repl_reg[i] <= cfg_data[CHAR_W*(i%8) +: CHAR_W];
                        end
                    end
                end
                REG_REPLACEMENT_HIGH:
                begin
                    for (int i = 0; i < MAX_REPLACEMENT; i++)
                    begin
                        if (i >= 8)
                        begin
                            repl_reg[i] <= cfg_data[CHAR_W*(i%8) +: CHAR_W];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the lengths into their usable ranges.
    always_comb
    begin
        if (plen_reg == '0)
        begin
            plen_eff = PLEN_W'(1);
        end
        else if (plen_reg > PLEN_W'(MAX_PATTERN))
        begin
            plen_eff = PLEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen_eff = plen_reg;
        end
        rlen_eff = (rlen_reg > RLEN_W'(MAX_REPLACEMENT)) ? RLEN_W'(MAX_REPLACEMENT) : rlen_reg;
        for (int i = 0; i < MAX_REPLACEMENT; i++)
        begin
            repl_vec[CHAR_W*i +: CHAR_W] = repl_reg[i];
        end
    end

    assign full = q_full;
    assign take = push && !q_full;

    swr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .in_char       (in_char),
        .in_last       (in_last),
        .pattern_bytes (pattern_reg),
        .plen          (plen_eff),
        .cmd           (front_cmd),
        .win_count     (win_count)
    );

    swr_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (take),
        .q_in    (front_cmd),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (head_cmd),
        .q_empty (q_empty)
    );

    swr_back #(
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .rlen      (rlen_eff),
        .repl_vec  (repl_vec),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

    // The window count stays below MAX_PATTERN between transactions.
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_count < CNT_W'(MAX_PATTERN))
        else $error("window count reached the pattern limit");

    // The end of a string leaves the window empty.
    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last) |=> (win_count == '0))
        else $error("window not cleared after the last byte");

    // An empty-string marker is the final transaction and carries a zero byte.
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_empty) |-> (out_last && (out_char == '0)))
        else $error("malformed empty-string marker");

endmodule
